[hw/rtl/sobel_edge_magnitude_unit_assert.svh]
// Assertion helpers for the edge unit.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SEMU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SEMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sobel_pkg.sv]
`timescale 1ns / 1ps

package sobel_pkg;

   localparam int PIX_W      = 8;
   localparam int CSR_W      = 13;
   localparam int POS_W      = 12;
   localparam int GRAD_W     = 10;   // |kernel response| <= 1020
   localparam int RAD_W      = 16;
   localparam int ROOT_STEPS = 8;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CSR_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CSR_W-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam logic [CSR_W-1:0] SIZE_MIN     = 13'd3;

   // 255*255: at or above this the magnitude saturates
   localparam logic [20:0] SAT_LIMIT = 21'd65025;

   // floor(s/3) for s <= 765 via reciprocal 2731/8192
   localparam logic [11:0] DIV3_RECIP = 12'd2731;

   function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
      logic [9:0]  s;
      logic [21:0] p;
      s = 10'(r) + 10'(g) + 10'(b);
      p = 22'(s) * 22'(DIV3_RECIP);
      return p[20:13];
   endfunction

endpackage

[hw/rtl/sobel_edge_magnitude_unit.sv]
`timescale 1ns / 1ps
// Sobel edge unit: RGB words in raster order are turned to gray, kept in two
// line memories and a 3x3 window, and every interior pixel yields one word of
// 255 - min(255, floor(sqrt(gx^2 + gy^2))) with its column and row; tlast marks
// the last interior pixel of a frame. Border pixels produce no output word.
// One pixel is in work at a time: a border pixel gets the memory read, then
// write-back and window update; an interior pixel then takes the two squaring
// steps and the 8-step bit-serial square root. The output word is registered, so
// a stalled rsp side holds the block only when the next result is ready. The user
// must write frame_width/frame_height on csr while idle; the block does not check.
`include "sobel_edge_magnitude_unit_assert.svh"

module sobel_edge_magnitude_unit #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // red, green, blue
   input  logic                          req_tuser,   // frame_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,   // edge_value, out_col, out_row
   output logic                          rsp_tlast,   // frame_last
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [sobel_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int XW = (AW + 1 > sobel_pkg::CSR_W) ? AW + 1 : sobel_pkg::CSR_W;
   localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_SQ   = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_ROOT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int PW = sobel_pkg::PIX_W;
   localparam int GW = sobel_pkg::GRAD_W;
   localparam int PS = sobel_pkg::POS_W;
   localparam int RW = sobel_pkg::RAD_W;

   // line memories
   logic [PW-1:0] upper_mem  [MAX_WIDTH];
   logic [PW-1:0] middle_mem [MAX_WIDTH];
   logic [PW-1:0] upper_q_ff, middle_q_ff;

   logic [2:0]    state_ff, state_in;
   logic [sobel_pkg::CSR_W-1:0] frame_width_ff, frame_width_in;
   logic [sobel_pkg::CSR_W-1:0] frame_height_ff, frame_height_in;
   logic [AW-1:0] col_count_ff, col_count_in;
   logic [PS-1:0] row_count_ff, row_count_in;
   logic [PW-1:0] tap_ff [6];
   logic [PW-1:0] tap_in [6];

   logic [AW-1:0] col_ff, col_in;
   logic [PS-1:0] row_ff, row_in;
   logic [PW-1:0] gray_ff, gray_in;
   logic          last_ff, last_in;
   logic [GW-1:0] gh_ff, gh_in, gv_ff, gv_in;
   logic [19:0]   sq_ff, sq_in;
   logic          sat_ff, sat_in;
   logic [RW-1:0] rad_sh_ff, rad_sh_in, rad_orig_ff, rad_orig_in;
   logic [PW-1:0] root_ff, root_in;
   logic [9:0]    rem_ff, rem_in;
   logic [2:0]    step_ff, step_in;

   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept, mem_rd, mem_wr, slot_free;
   logic [AW-1:0] col_sel;
   logic [XW-1:0] w_x, col_x, col_out_x;
   logic [sobel_pkg::CSR_W-1:0] h_x, row_x;
   logic [GW-1:0] left_s, right_s, upper_s, lower_s;
   logic [19:0]   gv_sq;
   logic [20:0]   sum_w;
   logic [11:0]   cur_rem, trial;
   logic          interior;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // effective frame size
   always_comb begin
      w_x = XW'(frame_width_ff);
      if (w_x < XW'(sobel_pkg::SIZE_MIN)) begin
         w_x = XW'(sobel_pkg::SIZE_MIN);
      end
      if (w_x > MAXW_X) begin
         w_x = MAXW_X;
      end
      h_x = frame_height_ff;
      if (h_x < sobel_pkg::SIZE_MIN) begin
         h_x = sobel_pkg::SIZE_MIN;
      end
      if (h_x > sobel_pkg::HEIGHT_LIMIT) begin
         h_x = sobel_pkg::HEIGHT_LIMIT;
      end
   end

   assign col_x    = XW'(col_ff);
   assign row_x    = sobel_pkg::CSR_W'(row_ff);
   assign interior = (col_x >= XW'(2)) && (row_ff >= PS'(2)) && (col_x < w_x) && (row_x < h_x);
   assign col_out_x = col_x - XW'(1);

   // window sums: taps are indexed row*2 + column (left, center)
   assign left_s  = GW'(tap_ff[0]) + GW'({tap_ff[2], 1'b0}) + GW'(tap_ff[4]);
   assign right_s = GW'(upper_q_ff) + GW'({middle_q_ff, 1'b0}) + GW'(gray_ff);
   assign upper_s = GW'(tap_ff[0]) + GW'({tap_ff[1], 1'b0}) + GW'(upper_q_ff);
   assign lower_s = GW'(tap_ff[4]) + GW'({tap_ff[5], 1'b0}) + GW'(gray_ff);

   assign gv_sq   = 20'(gv_ff) * 20'(gv_ff);
   assign sum_w   = 21'(sq_ff) + 21'(gv_sq);

   // one root bit per cycle
   assign cur_rem = {rem_ff, rad_sh_ff[RW-1:RW-2]};
   assign trial   = 12'({root_ff, 2'b01});

   always_comb begin
      if (!req_tuser && (XW'(col_count_ff) < MAXW_X)) begin
         col_sel = col_count_ff;
      end else begin
         col_sel = '0;
      end
   end

   assign mem_rd = accept;
   assign mem_wr = (state_ff == ST_READ);

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_count_in    = col_count_ff;
      row_count_in    = row_count_ff;
      tap_in          = tap_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      gray_in         = gray_ff;
      last_in         = last_ff;
      gh_in           = gh_ff;
      gv_in           = gv_ff;
      sq_in           = sq_ff;
      sat_in          = sat_ff;
      rad_sh_in       = rad_sh_ff;
      rad_orig_in     = rad_orig_ff;
      root_in         = root_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_we) begin
         case (csr_addr)
            sobel_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            sobel_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_in   = col_sel;
               row_in   = req_tuser ? '0 : row_count_ff;
               gray_in  = sobel_pkg::gray_of(req_tdata[7:0], req_tdata[15:8],
                                             req_tdata[23:16]);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            gh_in   = (right_s >= left_s) ? right_s - left_s : left_s - right_s;
            gv_in   = (lower_s >= upper_s) ? lower_s - upper_s : upper_s - lower_s;
            last_in = (col_x == w_x - XW'(1)) && (row_x == h_x - sobel_pkg::CSR_W'(1));
            tap_in[0] = tap_ff[1];
            tap_in[1] = upper_q_ff;
            tap_in[2] = tap_ff[3];
            tap_in[3] = middle_q_ff;
            tap_in[4] = tap_ff[5];
            tap_in[5] = gray_ff;
            if (col_x + XW'(1) >= w_x) begin
               col_count_in = '0;
               if (row_x + sobel_pkg::CSR_W'(1) >= h_x) begin
                  row_count_in = '0;
               end else begin
                  row_count_in = row_ff + PS'(1);
               end
            end else begin
               col_count_in = col_ff + AW'(1);
               row_count_in = row_ff;
            end
            state_in = interior ? ST_SQ : ST_IDLE;
         end
         ST_SQ: begin
            sq_in    = 20'(gh_ff) * 20'(gh_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sat_in      = (sum_w >= sobel_pkg::SAT_LIMIT);
            rad_sh_in   = sum_w[RW-1:0];
            rad_orig_in = sum_w[RW-1:0];
            root_in     = '0;
            rem_in      = '0;
            step_in     = '0;
            state_in    = ST_ROOT;
         end
         ST_ROOT: begin
            if (cur_rem >= trial) begin
               rem_in  = 10'(cur_rem - trial);
               root_in = {root_ff[PW-2:0], 1'b1};
            end else begin
               rem_in  = cur_rem[9:0];
               root_in = {root_ff[PW-2:0], 1'b0};
            end
            rad_sh_in = {rad_sh_ff[RW-3:0], 2'b00};
            step_in   = step_ff + 3'd1;
            if (step_ff == 3'(sobel_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {row_ff - PS'(1), col_out_x[PS-1:0],
                                sat_ff ? {PW{1'b0}} : ~root_ff};
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_width_ff  <= sobel_pkg::WIDTH_RESET;
         frame_height_ff <= sobel_pkg::HEIGHT_RESET;
         col_count_ff    <= '0;
         row_count_ff    <= '0;
         tap_ff          <= '{default: '0};
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_count_ff    <= col_count_in;
         row_count_ff    <= row_count_in;
         tap_ff          <= tap_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      gray_ff     <= gray_in;
      last_ff     <= last_in;
      gh_ff       <= gh_in;
      gv_ff       <= gv_in;
      sq_ff       <= sq_in;
      sat_ff      <= sat_in;
      rad_sh_ff   <= rad_sh_in;
      rad_orig_ff <= rad_orig_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Read on accept, write back the next cycle; one pixel at a time, so a
   // read never overlaps a pending write to the same column.
   always_ff @(posedge clock) begin
      if (mem_rd) begin
         upper_q_ff  <= upper_mem[col_sel];
         middle_q_ff <= middle_mem[col_sel];
      end
      if (mem_wr) begin
         upper_mem[col_ff]  <= middle_q_ff;
         middle_mem[col_ff] <= gray_ff;
      end
   end

   `SEMU_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == ST_READ, "accepted word did not start a memory read")
   `SEMU_ASSERT_NEXT(a_result_issued, clock, reset, (state_ff == ST_DONE) && slot_free, rsp_tvalid_ff && (state_ff == ST_IDLE), "finished result not loaded into output register")
   `SEMU_ASSERT_NOW(a_root_exact, clock, reset, (state_ff == ST_DONE) && !sat_ff, (17'(root_ff) * 17'(root_ff) <= 17'(rad_orig_ff)) && ((17'(root_ff) + 17'd1) * (17'(root_ff) + 17'd1) > 17'(rad_orig_ff)), "square root is not the floor root")
   `SEMU_ASSERT_NOW(a_col_range, clock, reset, 1'b1, XW'(col_count_ff) < MAXW_X, "column counter beyond line memory depth")

endmodule

[test/sobel_edge_magnitude_unit_test.sv]
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit_test;

   localparam int LINE_DEPTH   = 4096;
   localparam int SETTLE_WAIT  = 40;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_PCT     = 11;

   typedef struct packed {
      logic [7:0]  edge_value;
      logic [11:0] out_col;
      logic [11:0] out_row;
      logic        frame_last;
   } edge_word_type;

   // Tracks gray line stores and window taps, queues the edge word each interior pixel yields.
   class edge_map_scoreboard;
      logic [7:0]    upper_line[LINE_DEPTH];
      logic [7:0]    middle_line[LINE_DEPTH];
      logic [7:0]    taps[6];
      int            col_pos;
      int            row_pos;
      logic [12:0]   width_reg;
      logic [12:0]   height_reg;
      edge_word_type edge_words[$];
      int            errors;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i] = 8'd0;
            middle_line[i] = 8'd0;
         end
         foreach (taps[i]) taps[i] = 8'd0;
         col_pos = 0;
         row_pos = 0;
         width_reg = sobel_pkg::WIDTH_RESET;
         height_reg = sobel_pkg::HEIGHT_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic addr, logic [12:0] value);
         if (addr == sobel_pkg::CSR_FRAME_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      function int pending();
         return edge_words.size();
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
         int w, h, c, rw, gray, top, mid;
         int left, right, upper, lower, gh, gv, sum, mag;
         edge_word_type word;
         w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
         h = (height_reg < 3) ? 3 : ((height_reg > 4096) ? 4096 : int'(height_reg));
         gray = (int'(r) + int'(g) + int'(b)) / 3;
         c = fs ? 0 : col_pos;
         rw = fs ? 0 : row_pos;
         if (c >= LINE_DEPTH) c = 0;
         top = upper_line[c];
         mid = middle_line[c];
         upper_line[c] = mid[7:0];
         middle_line[c] = gray[7:0];
         if (c >= 2 && rw >= 2 && c < w && rw < h) begin
            left  = taps[0] + 2 * taps[2] + taps[4];
            right = top + 2 * mid + gray;
            upper = taps[0] + 2 * taps[1] + top;
            lower = taps[4] + 2 * taps[5] + gray;
            gh = (right > left) ? right - left : left - right;
            gv = (lower > upper) ? lower - upper : upper - lower;
            sum = gh * gh + gv * gv;
            mag = 0;
            if (sum >= 65025) mag = 255;
            else while ((mag + 1) * (mag + 1) <= sum) mag++;
            word.edge_value = 8'(255 - mag);
            word.out_col = 12'(c - 1);
            word.out_row = 12'(rw - 1);
            word.frame_last = (c == w - 1 && rw == h - 1);
            edge_words.push_back(word);
         end
         taps[0] = taps[1];
         taps[1] = top[7:0];
         taps[2] = taps[3];
         taps[3] = mid[7:0];
         taps[4] = taps[5];
         taps[5] = gray[7:0];
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (rw + 1 >= h) ? 0 : rw + 1;
         end else begin
            col_pos = c + 1;
            row_pos = rw;
         end
      endfunction

      function void check_word(edge_word_type got);
         edge_word_type want;
         if (edge_words.size() == 0) begin
            $error("edge word with none expected: edge_value %0d col %0d row %0d",
                   got.edge_value, got.out_col, got.out_row);
            errors++;
            return;
         end
         want = edge_words.pop_front();
         if (got.edge_value !== want.edge_value) begin
            $error("edge_value: expected %0d, actual %0d", want.edge_value, got.edge_value);
            errors++;
         end
         if (got.out_col !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
            errors++;
         end
         if (got.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
            errors++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, got.frame_last);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata = 24'd0;   // red, green, blue
   logic              req_tuser = 1'b0;    // frame_start
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;           // edge_value, out_col, out_row
   logic              rsp_tlast;           // frame_last
   logic              csr_we = 1'b0;
   logic              csr_addr = 1'b0;
   logic [sobel_pkg::CSR_W-1:0] csr_wdata = '0;

   edge_map_scoreboard edges = new();
   bit steady = 1'b0;
   int pixels_sent = 0;
   int cycle_count = 0;

   sobel_edge_magnitude_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sobel_edge_magnitude_unit_test failed");
         $finish;
      end
   end

   // downstream stall
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         edges.check_word({rsp_tdata[7:0], rsp_tdata[19:8], rsp_tdata[31:20], rsp_tlast});
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic fs);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {b, g, r};
      req_tuser = fs;
      do @(posedge clock); while (!req_tready);
      edges.note_pixel(r, g, b, fs);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (edges.pending() != 0) @(posedge clock);
      // a border pixel may still be in work
      repeat (SETTLE_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic addr, input logic [sobel_pkg::CSR_W-1:0] value);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      edges.write_reg(addr, value);
   endtask

   function automatic logic [7:0] channel(int base, int spread);
      int v;
      v = base + ((spread > 0) ? int'($urandom_range(spread)) : 0);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // spread 0 means fully random pixels; otherwise a ramp plus bounded noise
   task automatic send_frame(input int w, input int h, input int spread, input int step,
                             input bit fs_first, input bit stray_starts);
      int base, lvl;
      logic [23:0] pix;
      base = $urandom_range(200);
      for (int row = 0; row < h; row++) begin
         for (int c = 0; c < w; c++) begin
            lvl = (base + c * step + row * step / 2) % 230;
            pix = (spread == 0) ? 24'($urandom)
                                : {channel(lvl, spread), channel(lvl, spread), channel(lvl, spread)};
            send_pixel(pix[7:0], pix[15:8], pix[23:16],
                       (row == 0 && c == 0 && fs_first) ||
                       (stray_starts && $urandom_range(199) == 0));
         end
      end
   endtask

   initial begin
      int w_reg, h_reg, w_eff, h_eff, frames, spread, goal;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset width 640: one full row, then a narrow width picks up mid-row
      for (int i = 0; i < 640 + 2; i++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == 0);
      settle();
      write_csr(sobel_pkg::CSR_FRAME_WIDTH, 13'd3);
      for (int i = 0; i < 7; i++)
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      settle();

      // smallest frame: saturated step, flat frame via row wrap, restart mid-frame
      write_csr(sobel_pkg::CSR_FRAME_WIDTH, 13'd3);
      write_csr(sobel_pkg::CSR_FRAME_HEIGHT, 13'd3);
      for (int row = 0; row < 3; row++) begin
         send_pixel(8'd0, 8'd0, 8'd0, row == 0);
         send_pixel(row == 0 ? 8'd255 : 8'd0, row == 1 ? 8'd255 : 8'd0,
                    row == 2 ? 8'd255 : 8'd0, 1'b0);
         send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      end
      for (int i = 0; i < 9; i++) send_pixel(8'd17, 8'd34, 8'd51, 1'b0);
      send_pixel(8'd99, 8'd1, 8'd200, 1'b0);
      for (int i = 0; i < 9; i++)
         send_pixel(8'(i * 20), 8'(i * 25), 8'(i * 7 + 3), i == 0);
      settle();

      // shrink the frame while the position is beyond the new limits
      write_csr(sobel_pkg::CSR_FRAME_WIDTH, 13'd12);
      write_csr(sobel_pkg::CSR_FRAME_HEIGHT, 13'd6);
      for (int i = 0; i < 40; i++)
         send_pixel(channel(60, 30), channel(60, 30), channel(60, 30), i == 0);
      settle();
      write_csr(sobel_pkg::CSR_FRAME_WIDTH, 13'd3);
      for (int i = 0; i < 16; i++)
         send_pixel(channel(90, 50), channel(90, 50), channel(90, 50), 1'b0);
      settle();
      write_csr(sobel_pkg::CSR_FRAME_HEIGHT, 13'd3);
      for (int i = 0; i < 24; i++)
         send_pixel(channel(30, 80), channel(30, 80), channel(30, 80), 1'b0);
      settle();

      goal = pixels_sent + RANDOM_ITEMS;
      while (pixels_sent < goal) begin
         // first half runs with no idling on either side
         steady = (goal - pixels_sent > RANDOM_ITEMS / 2);
         case ($urandom_range(9))
            0:       w_reg = $urandom_range(2);
            1, 2:    w_reg = $urandom_range(40, 11);
            default: w_reg = $urandom_range(10, 3);
         endcase
         h_reg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
         w_eff = (w_reg < 3) ? 3 : w_reg;
         h_eff = (h_reg < 3) ? 3 : h_reg;
         write_csr(sobel_pkg::CSR_FRAME_WIDTH, 13'(w_reg));
         write_csr(sobel_pkg::CSR_FRAME_HEIGHT, 13'(h_reg));
         frames = $urandom_range(3, 1);
         for (int f = 0; f < frames; f++) begin
            case ($urandom_range(4))
               0:       spread = 0;
               1:       spread = 4;
               2:       spread = 15;
               default: spread = 45;
            endcase
            send_frame(w_eff, h_eff, spread, $urandom_range(12),
                       (f == 0) || ($urandom_range(1) == 1), 1'b1);
         end
         settle();
      end
      steady = 1'b0;

      settle();
      if (edges.errors == 0 && edges.pending() == 0)
         $display("sobel_edge_magnitude_unit_test passed");
      else
         $display("sobel_edge_magnitude_unit_test failed");
      $finish;
   end

endmodule
